### rtl/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

   localparam int SQ_DIM  = 5;
   localparam int CODE_W  = 5;
   localparam int ROW_W   = SQ_DIM * CODE_W;
   localparam int POS_W   = 3;
   localparam int CSR_IDX_W = 3;

   // Key square: [row][column] of 5-bit letter codes.
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [SQ_DIM-1:0][CODE_W-1:0] row_type;
   typedef row_type [SQ_DIM-1:0] square_type;
   typedef logic [POS_W-1:0] pos_type;

   // Where one lane found its letter.
   typedef struct packed {
      logic    found;
      pos_type row;
      pos_type col;
   } loc_type;

   // Reset square ABCDE / FGHJK / LMNOP / QRSTU / VWXYZ.
   localparam logic [ROW_W-1:0] ROW0_RESET = 25'd4294688;
   localparam logic [ROW_W-1:0] ROW1_RESET = 25'd10788037;
   localparam logic [ROW_W-1:0] ROW2_RESET = 25'd16201099;
   localparam logic [ROW_W-1:0] ROW3_RESET = 25'd21613104;
   localparam logic [ROW_W-1:0] ROW4_RESET = 25'd27025109;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW4 = 3'd4;

   localparam pos_type POS_LAST = pos_type'(SQ_DIM - 1);

   // Step one position with wrap inside the square.
   function automatic pos_type pos_next(input pos_type p);
      pos_type r;
      if (p >= POS_LAST) begin
         r = '0;
      end else begin
         r = p + pos_type'(1);
      end
      return r;
   endfunction

   // Letter at a position; positions past the square read as zero.
   function automatic code_type cell_at(input square_type sq, input pos_type r,
                                        input pos_type c);
      code_type v;
      v = '0;
      if (r <= POS_LAST && c <= POS_LAST) begin
         v = sq[r][c];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/pfe_lane.sv
`default_nettype none

module pfe_lane (
   input  pfe_pkg::square_type square,
   input  pfe_pkg::code_type   letter,
   output pfe_pkg::loc_type    loc
);
   import pfe_pkg::*;

   // 25 compares side by side; scan backward so the first row-major hit wins.
   always_comb begin
      loc = '0;
      for (int r = SQ_DIM - 1; r >= 0; r--) begin
         for (int c = SQ_DIM - 1; c >= 0; c--) begin
            if (square[r][c] == letter) begin
               loc.found = 1'b1;
               loc.row   = pos_type'(r);
               loc.col   = pos_type'(c);
            end
         end
      end
   end

endmodule

`default_nettype wire

### rtl/pfe_merge.sv
`default_nettype none

module pfe_merge (
   input  pfe_pkg::square_type square,
   input  pfe_pkg::loc_type    loc_a,
   input  pfe_pkg::loc_type    loc_b,
   output pfe_pkg::code_type   cipher_a,
   output pfe_pkg::code_type   cipher_b,
   output logic                missing
);
   import pfe_pkg::*;

   always_comb begin
      cipher_a = '0;
      cipher_b = '0;
      missing  = 1'b0;
      priority if (!loc_a.found || !loc_b.found) begin
         missing = 1'b1;
      end else if (loc_a.col == loc_b.col) begin
         // same column (also a doubled letter): one row down
         cipher_a = cell_at(square, pos_next(loc_a.row), loc_a.col);
         cipher_b = cell_at(square, pos_next(loc_b.row), loc_b.col);
      end else if (loc_a.row == loc_b.row) begin
         cipher_a = cell_at(square, loc_a.row, pos_next(loc_a.col));
         cipher_b = cell_at(square, loc_b.row, pos_next(loc_b.col));
      end else begin
         // rectangle: swap columns
         cipher_a = cell_at(square, loc_a.row, loc_b.col);
         cipher_b = cell_at(square, loc_b.row, loc_a.col);
      end
   end

endmodule

`default_nettype wire

### rtl/playfair_pair_encrypt.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    first_letter, second_letter (5b each)
// rsp_      out        rsp_valid/stall    first_cipher, second_cipher, letter_missing
// csr_      in         csr_write_enable   csr_index (3b), csr_write_data (25b)
//
// One pair per cycle sustained while rsp is not stalled; a pair is registered in stage 1, then in the output register.
// Stage 1: two locate lanes (25 compares each) -> registered positions.
// Stage 2: merge applies the Playfair rules -> output register.
// Reset (synchronous) empties both stages and loads the default square.
// A rsp stall holds the output register; req_stall rises only once both
// stages are full and the output is stalled.

module playfair_pair_encrypt (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pfe_pkg::code_type                      req_first_letter,
   input  pfe_pkg::code_type                      req_second_letter,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pfe_pkg::code_type                      rsp_first_cipher,
   output pfe_pkg::code_type                      rsp_second_cipher,
   output logic                                   rsp_letter_missing,

   input  logic                                   csr_write_enable,
   input  logic [pfe_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pfe_pkg::ROW_W-1:0]              csr_write_data
);
   import pfe_pkg::*;

   // Key square registers
   square_type square_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff[0] <= row_type'(ROW0_RESET);
         square_ff[1] <= row_type'(ROW1_RESET);
         square_ff[2] <= row_type'(ROW2_RESET);
         square_ff[3] <= row_type'(ROW3_RESET);
         square_ff[4] <= row_type'(ROW4_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW0: square_ff[0] <= row_type'(csr_write_data);
            CSR_ROW1: square_ff[1] <= row_type'(csr_write_data);
            CSR_ROW2: square_ff[2] <= row_type'(csr_write_data);
            CSR_ROW3: square_ff[3] <= row_type'(csr_write_data);
            CSR_ROW4: square_ff[4] <= row_type'(csr_write_data);
            default:  ; // indexes past row 4 are dropped
         endcase
      end
   end

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic adv1, adv2;
   logic req_xfer;

   assign adv2      = !rsp_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign req_xfer  = req_valid && adv1;

   assign s1_valid_in  = adv1 ? req_valid : s1_valid_ff;
   assign rsp_valid_in = adv2 ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1: locate lanes
   loc_type loc_a_in, loc_b_in;
   loc_type loc_a_ff, loc_b_ff;

   pfe_lane u_lane_a (
      .square (square_ff),
      .letter (req_first_letter),
      .loc    (loc_a_in)
   );

   pfe_lane u_lane_b (
      .square (square_ff),
      .letter (req_second_letter),
      .loc    (loc_b_in)
   );

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         loc_a_ff <= loc_a_in;
         loc_b_ff <= loc_b_in;
      end
   end

   // Stage 2: rule merge into the output register
   code_type first_cipher_in, second_cipher_in;
   logic     missing_in;
   code_type first_cipher_ff, second_cipher_ff;
   logic     missing_ff;

   pfe_merge u_merge (
      .square   (square_ff),
      .loc_a    (loc_a_ff),
      .loc_b    (loc_b_ff),
      .cipher_a (first_cipher_in),
      .cipher_b (second_cipher_in),
      .missing  (missing_in)
   );

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         first_cipher_ff  <= first_cipher_in;
         second_cipher_ff <= second_cipher_in;
         missing_ff       <= missing_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_cipher   = first_cipher_ff;
   assign rsp_second_cipher  = second_cipher_ff;
   assign rsp_letter_missing = missing_ff;

   // Checks
   a_req_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted pair not held in stage 1");

   a_s1_moves_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && adv2 |=> rsp_valid)
      else $error("stage 1 pair did not reach the output");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_letter_missing |->
         rsp_first_cipher == '0 && rsp_second_cipher == '0)
      else $error("missing letter with nonzero cipher");

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfe_pkg::*;

   // Run control
   localparam int CYCLE_LIMIT   = 200000;  // generous watchdog
   localparam int DRAIN_CYCLES  = 4;       // margin after the last result transfer
   localparam int HOLD_CYCLES   = 40;      // long rsp hold-off for the fill-up test
   localparam int PHASE_PAIRS   = 140;
   localparam int RANDOM_PHASES = 8;
   localparam int HOLD_PAIRS    = 40;
   localparam int STREAM_PAIRS  = 100;

   // Indexes past the last square row; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Letter codes used by the directed pairs (0=A .. 25=Z).
   localparam code_type LTR_A    = 5'd0;
   localparam code_type LTR_B    = 5'd1;
   localparam code_type LTR_D    = 5'd3;
   localparam code_type LTR_E    = 5'd4;
   localparam code_type LTR_F    = 5'd5;
   localparam code_type LTR_G    = 5'd6;
   localparam code_type LTR_I    = 5'd8;   // not in the reset square
   localparam code_type LTR_Q    = 5'd16;
   localparam code_type LTR_V    = 5'd21;
   localparam code_type LTR_Z    = 5'd25;
   localparam code_type CODE_TOP = 5'd31;  // highest 5-bit code, not a letter

   // One result transfer as the checker sees it.
   typedef struct packed {
      code_type first_cipher;
      code_type second_cipher;
      logic     letter_missing;
   } cipher_pair_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   code_type             req_first_letter = '0;
   code_type             req_second_letter = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   code_type             rsp_first_cipher;
   code_type             rsp_second_cipher;
   logic                 rsp_letter_missing;

   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0]     csr_write_data = '0;

   // Predictor copy of the key square, kept in step with every csr write.
   square_type           key_square;
   cipher_pair_t         expected_ciphers[$];

   // Idling controls. idle_on is only read by the sender, so it is set
   // blocking; stall_on and hold_pending cross into the stall process and
   // are set nonblocking so the handoff never depends on process order.
   bit                   idle_on = 1'b1;
   bit                   stall_on = 1'b0;
   bit                   hold_pending = 1'b0;

   int                   cycle_count = 0;
   int                   mismatches = 0;
   int                   pairs_sent = 0;
   int                   results_seen = 0;
   int                   missing_seen = 0;
   int                   squares_loaded = 0;
   int                   input_stall_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   playfair_pair_encrypt u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_letter   (req_first_letter),
      .req_second_letter  (req_second_letter),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_first_cipher   (rsp_first_cipher),
      .rsp_second_cipher  (rsp_second_cipher),
      .rsp_letter_missing (rsp_letter_missing),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Row-major scan, so a letter that sits in the square twice resolves to
   // its first position.
   function automatic bit find_letter(input code_type code, output int row,
                                      output int col);
      bit hit;
      hit = 1'b0;
      row = 0;
      col = 0;
      for (int r = 0; r < SQ_DIM && !hit; r++) begin
         for (int c = 0; c < SQ_DIM && !hit; c++) begin
            if (key_square[r][c] == code) begin
               hit = 1'b1;
               row = r;
               col = c;
            end
         end
      end
      return hit;
   endfunction

   // Column test comes first: a doubled letter shares its own column and
   // so moves down, not right.
   function automatic cipher_pair_t encipher_pair(input code_type a, input code_type b);
      cipher_pair_t res;
      int           r1, c1, r2, c2;
      bit           f1, f2;
      res = '0;
      f1 = find_letter(a, r1, c1);
      f2 = find_letter(b, r2, c2);
      if (!f1 || !f2) begin
         res.letter_missing = 1'b1;
      end else if (c1 == c2) begin
         res.first_cipher  = key_square[(r1 + 1) % SQ_DIM][c1];
         res.second_cipher = key_square[(r2 + 1) % SQ_DIM][c2];
      end else if (r1 == r2) begin
         res.first_cipher  = key_square[r1][(c1 + 1) % SQ_DIM];
         res.second_cipher = key_square[r2][(c2 + 1) % SQ_DIM];
      end else begin
         res.first_cipher  = key_square[r1][c2];
         res.second_cipher = key_square[r2][c1];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------

   // One pair over the req channel. Valid stays high after the transfer so a
   // following call can reuse the same step without a low/high glitch.
   task automatic send_pair(input code_type a, input code_type b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_first_letter  <= a;
      req_second_letter <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_ciphers.push_back(encipher_pair(a, b));
      pairs_sent++;
   endtask

   // Drop valid and let every outstanding result come home, so the block is
   // idle before the next csr write.
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (expected_ciphers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Enable is lowered in the cycle after the write so back-to-back calls
   // never put two assignments on it in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      if (idx <= CSR_ROW4) begin
         key_square[idx] = data;
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_square(input square_type sq);
      for (int r = 0; r < SQ_DIM; r++) begin
         write_reg(CSR_IDX_W'(r), sq[r]);
      end
      squares_loaded++;
   endtask

   // 25 distinct letters out of 26, so exactly one letter is left out.
   function automatic square_type shuffled_square();
      square_type sq;
      int         pool[26];
      int         j, tmp;
      for (int i = 0; i < 26; i++) pool[i] = i;
      for (int i = 25; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = pool[i];
         pool[i] = pool[j];
         pool[j] = tmp;
      end
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            sq[r][c] = code_type'(pool[r * SQ_DIM + c]);
         end
      end
      return sq;
   endfunction

   // Raw 5-bit codes: duplicates, codes past Z, and many absent letters.
   function automatic square_type raw_square();
      square_type sq;
      for (int r = 0; r < SQ_DIM; r++) begin
         sq[r] = row_type'($urandom);
      end
      return sq;
   endfunction

   // Mostly pairs drawn from the square so the row, column and rectangle
   // rules all get real traffic; a tenth is free 5-bit noise.
   function automatic void pick_pair(output code_type a, output code_type b);
      int dice, r1, c1;
      dice = $urandom_range(0, 9);
      r1 = $urandom_range(0, SQ_DIM - 1);
      c1 = $urandom_range(0, SQ_DIM - 1);
      a = key_square[r1][c1];
      if (dice == 0) begin
         a = code_type'($urandom_range(0, 31));
         b = code_type'($urandom_range(0, 31));
      end else if (dice <= 2) begin
         b = key_square[r1][$urandom_range(0, SQ_DIM - 1)];
      end else if (dice <= 4) begin
         b = key_square[$urandom_range(0, SQ_DIM - 1)][c1];
      end else if (dice == 5) begin
         b = a;
      end else begin
         b = key_square[$urandom_range(0, SQ_DIM - 1)][$urandom_range(0, SQ_DIM - 1)];
      end
   endfunction

   task automatic send_random_pairs(input int count);
      code_type a, b;
      repeat (count) begin
         pick_pair(a, b);
         send_pair(a, b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int held;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending <= 1'b0;
            rsp_stall    <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: each rsp transfer against the oldest expectation.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                              input logic [CODE_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : cipher_check
      cipher_pair_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_ciphers.size() == 0) begin
            mismatches++;
            $display("%0t: result transfer with nothing expected, actual %0d/%0d missing=%0b",
                     $time, rsp_first_cipher, rsp_second_cipher, rsp_letter_missing);
         end else begin
            want = expected_ciphers.pop_front();
            if (want.letter_missing) missing_seen++;
            check_field("first_cipher", want.first_cipher, rsp_first_cipher);
            check_field("second_cipher", want.second_cipher, rsp_second_cipher);
            check_field("letter_missing", CODE_W'(want.letter_missing),
                        CODE_W'(rsp_letter_missing));
         end
      end
   end

   // Watchdog, and a tally of cycles where the block pushed back on req.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_ciphers.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset square ABCDE / FGHJK / LMNOP / QRSTU / VWXYZ, no csr writes yet.
   task automatic test_reset_square();
      send_pair(LTR_A, LTR_B);       // same row
      send_pair(LTR_D, LTR_E);       // same row, E wraps to column 0
      send_pair(LTR_A, LTR_F);       // same column
      send_pair(LTR_Q, LTR_V);       // same column, V wraps to row 0
      send_pair(LTR_A, LTR_G);       // rectangle
      send_pair(LTR_G, LTR_A);       // rectangle, order swapped
      send_pair(LTR_E, LTR_V);       // rectangle across the whole square
      send_pair(LTR_A, LTR_Z);       // lowest and highest letter
      send_pair(LTR_A, LTR_A);       // doubled letter takes the column rule
      send_pair(LTR_I, LTR_A);       // first letter absent
      send_pair(LTR_A, LTR_I);       // second letter absent
      send_pair(CODE_TOP, LTR_Z);    // code past Z, absent from this square
      finish_phase();
   endtask

   // Dropped writes to spare indexes, then an all-zero row, an all-ones row
   // and rows holding codes past Z.
   task automatic test_edge_squares();
      square_type sq;
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '0);
      send_pair(CODE_TOP, LTR_A);    // still absent if the spare writes were dropped
      send_pair(LTR_B, LTR_D);
      finish_phase();

      sq[0] = '0;                    // every cell A
      sq[1] = '1;                    // every cell code 31
      for (int c = 0; c < SQ_DIM; c++) begin
         sq[2][c] = code_type'(26 + c);
         sq[3][c] = code_type'(1 + c);
         sq[4][c] = code_type'(6 + c);
      end
      load_square(sq);
      send_pair(LTR_A, LTR_A);                               // duplicates: first match wins
      send_pair(CODE_TOP, LTR_A);                            // both in column 0
      send_pair(key_square[2][4], key_square[2][0]);         // row wrap among high codes
      send_pair(key_square[3][0], key_square[2][4]);         // rectangle
      send_pair(key_square[4][4], key_square[4][0]);         // same row
      send_pair(LTR_Z, key_square[3][2]);                    // Z absent here
      finish_phase();
   endtask

   // Random squares, well-formed and raw, each followed by random pairs.
   task automatic test_random_squares();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p % 3 == 2) begin
            write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                      ROW_W'($urandom));
         end
         if (p % 2 == 0) begin
            load_square(shuffled_square());
         end else begin
            load_square(raw_square());
         end
         send_random_pairs(PHASE_PAIRS);
         finish_phase();
      end
   endtask

   // Receiver holds off long enough that both stages fill and req stalls
   // while the sender keeps offering pairs.
   task automatic test_backpressure();
      load_square(shuffled_square());
      hold_pending <= 1'b1;
      send_random_pairs(HOLD_PAIRS);
      finish_phase();
   endtask

   // Full-rate stream on the reset square values, no gaps on either side.
   task automatic test_streaming();
      square_type sq;
      sq[0] = ROW0_RESET;
      sq[1] = ROW1_RESET;
      sq[2] = ROW2_RESET;
      sq[3] = ROW3_RESET;
      sq[4] = ROW4_RESET;
      load_square(sq);
      idle_on = 1'b0;
      stall_on <= 1'b0;
      send_random_pairs(STREAM_PAIRS);
      finish_phase();
   endtask

   initial begin
      key_square[0] = ROW0_RESET;
      key_square[1] = ROW1_RESET;
      key_square[2] = ROW2_RESET;
      key_square[3] = ROW3_RESET;
      key_square[4] = ROW4_RESET;
      repeat (4) @(posedge clock);
      reset    <= 1'b0;
      stall_on <= 1'b1;
      @(posedge clock);

      test_reset_square();
      test_edge_squares();
      test_random_squares();
      test_backpressure();
      test_streaming();

      $display("%0d pairs over %0d loaded key squares plus the reset square, %0d results",
               pairs_sent, squares_loaded, results_seen);
      $display("%0d missing-letter results, req stalled for %0d cycles, %0d mismatches",
               missing_seen, input_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
